@@ rtl/hfsm_pkg.sv @@
// ----------------------------------------------------------------------------
// hfsm_pkg
// Shared types and constants of the hierarchical state machine sequencer:
// command and result codes, controller states, control/status structs.
// ----------------------------------------------------------------------------
package hfsm_pkg;

  localparam int ID_W   = 6;
  localparam int OP_W   = 3;
  localparam int KIND_W = 2;
  localparam int ERR_W  = 2;

  localparam int NUM_STATES_DEF = 64;
  localparam int MAX_DEPTH_DEF  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_DEFINE,
    OP_START,
    OP_TRANS,
    OP_STOP,
    OP_QUERY
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXIT,
    KIND_ENTER,
    KIND_QUERY,
    KIND_DONE
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK,
    ERR_UNKNOWN,
    ERR_DEPTH
  } err_e;

  // where the event state of a result comes from
  typedef enum logic [1:0] {
    SRC_SID,
    SRC_PATH,
    SRC_CHAIN
  } src_e;

  typedef enum logic [2:0] {
    LV_HOLD,
    LV_INC,
    LV_DEC,
    LV_TL,
    LV_CUR,
    LV_EF
  } lv_op_e;

  typedef enum logic [1:0] {
    EF_HOLD,
    EF_ZERO,
    EF_LV
  } ef_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_SELF_ENTER,
    S_WALK_RD,
    S_WALK,
    S_SCAN,
    S_BRANCH,
    S_EXIT,
    S_ENTER
  } state_e;

  typedef struct packed {
    logic   accept;       // latch command, read entry of state or parent
    logic   lookup;       // entry read data valid, latch target level
    logic   rd_walk;      // read entry at walk pointer
    logic   def_write;    // commit a state definition
    logic   x_init;       // walk pointer to target
    logic   chain_write;  // chain[lv] <= pointer, pointer to parent
    logic   path_write;   // path[lv] <= chain[lv]
    lv_op_e lv_op;
    ef_op_e ef_op;
    logic   stop_machine;
    logic   run_target;   // running, current level to target level
    logic   emit;
    kind_e  emit_kind;
    err_e   emit_err;
    src_e   emit_src;
    logic   emit_last;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            sid_known;
    logic            running;
    logic            self_hit;
    err_e            def_err;
    logic            scan_go;
    logic            exit_needed;
    logic            enter_follows;
    logic            lv_zero;
    logic            lv_is_ef;
    logic            lv_is_tl;
    logic            out_free;
  } status_t;

endpackage

@@ rtl/hierarchical_fsm_transition_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// hierarchical_fsm_transition_sequencer_unit
// Hierarchical state machine engine: state table, active path, and
// exit/entry event sequencing for start, transition and stop commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per
//   transaction: opcode, state_id, parent_id. Output channel (out_valid_o /
//   out_stall_i) returns one or more result transactions per command; the
//   final one has last_o set.
//   Define, query, stop-while-stopped and rejected commands load a single
//   result into the output register from the lookup state, once the
//   output register is free. A self-transition loads its exit from the
//   lookup state and its entry from the self-enter state.
//   Start and transition walk the target's parent chain out of the state
//   table, with a read state and a write state per level (one table read
//   port, registered read); a transition then compares it with the active
//   path one level per cycle. Then one exit or entry event is issued per
//   cycle while the output is free. A new command is taken once the last
//   result of the previous one sits in the output register.
//   Reset clears the defined flags and stops the machine; no clearing pass
//   is needed. A stalled receiver holds the output register and the
//   sequencer waits on it without losing or repeating events.
// ----------------------------------------------------------------------------
module hierarchical_fsm_transition_sequencer_unit #(
  parameter int NUM_STATES = hfsm_pkg::NUM_STATES_DEF,
  parameter int MAX_DEPTH  = hfsm_pkg::MAX_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [hfsm_pkg::OP_W-1:0]   opcode_i,
  input  logic [hfsm_pkg::ID_W-1:0]   state_id_i,
  input  logic [hfsm_pkg::ID_W-1:0]   parent_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hfsm_pkg::KIND_W-1:0] event_kind_o,
  output logic [hfsm_pkg::ID_W-1:0]   event_state_o,
  output logic                        is_active_o,
  output logic [hfsm_pkg::ERR_W-1:0]  error_o,
  output logic                        last_o
);
  import hfsm_pkg::*;

  cmd_t    cmd;
  status_t status;

  hfsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hfsm_dp #(
    .NUM_STATES (NUM_STATES),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .state_id_i    (state_id_i),
    .parent_id_i   (parent_id_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .event_kind_o  (event_kind_o),
    .event_state_o (event_state_o),
    .is_active_o   (is_active_o),
    .error_o       (error_o),
    .last_o        (last_o)
  );

endmodule

@@ rtl/hfsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// hfsm_ctrl
// Sequencing state machine: decodes a command after the table lookup, then
// steps the datapath through chain walk, path scan, exits and entries.
// ----------------------------------------------------------------------------
module hfsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hfsm_pkg::status_t status_i,
  output hfsm_pkg::cmd_t    cmd_o
);
  import hfsm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (status_i.out_free) begin
          case (status_i.op)
            OP_START: begin
              state_d = status_i.sid_known ? S_WALK_RD : S_IDLE;
            end
            OP_TRANS: begin
              if (!status_i.running || !status_i.sid_known) state_d = S_IDLE;
              else if (status_i.self_hit) state_d = S_SELF_ENTER;
              else state_d = S_WALK_RD;
            end
            OP_STOP: begin
              state_d = status_i.running ? S_BRANCH : S_IDLE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SELF_ENTER: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      S_WALK_RD: state_d = S_WALK;
      S_WALK: begin
        if (!status_i.lv_zero) state_d = S_WALK_RD;
        else if (status_i.op == OP_TRANS) state_d = S_SCAN;
        else state_d = S_BRANCH;
      end
      S_SCAN: begin
        if (!status_i.scan_go) state_d = S_BRANCH;
      end
      S_BRANCH: begin
        state_d = status_i.exit_needed ? S_EXIT : S_ENTER;
      end
      S_EXIT: begin
        if (status_i.out_free && status_i.lv_is_ef) begin
          state_d = status_i.enter_follows ? S_ENTER : S_IDLE;
        end
      end
      S_ENTER: begin
        if (status_i.out_free && status_i.lv_is_tl) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.lv_op     = LV_HOLD;
    cmd_o.ef_op     = EF_HOLD;
    cmd_o.emit_kind = KIND_DONE;
    cmd_o.emit_err  = ERR_OK;
    cmd_o.emit_src  = SRC_SID;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (status_i.out_free) begin
          case (status_i.op)
            OP_DEFINE: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_err  = status_i.def_err;
              cmd_o.emit_last = 1'b1;
              cmd_o.def_write = (status_i.def_err == ERR_OK);
            end
            OP_START: begin
              if (status_i.sid_known) begin
                cmd_o.x_init = 1'b1;
                cmd_o.lv_op  = LV_TL;
              end else begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_err  = ERR_UNKNOWN;
                cmd_o.emit_last = 1'b1;
              end
            end
            OP_TRANS: begin
              if (!status_i.running) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
              end else if (!status_i.sid_known) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_err  = ERR_UNKNOWN;
                cmd_o.emit_last = 1'b1;
              end else if (status_i.self_hit) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = KIND_EXIT;
              end else begin
                cmd_o.x_init = 1'b1;
                cmd_o.lv_op  = LV_TL;
              end
            end
            OP_STOP: begin
              if (status_i.running) begin
                cmd_o.ef_op = EF_ZERO;
              end else begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
              end
            end
            OP_QUERY: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_QUERY;
              cmd_o.emit_err  = status_i.sid_known ? ERR_OK : ERR_UNKNOWN;
              cmd_o.emit_last = 1'b1;
            end
            default: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
            end
          endcase
        end
      end
      S_SELF_ENTER: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_ENTER;
          cmd_o.emit_last = 1'b1;
        end
      end
      S_WALK_RD: begin
        cmd_o.rd_walk = 1'b1;
      end
      S_WALK: begin
        cmd_o.chain_write = 1'b1;
        if (!status_i.lv_zero) cmd_o.lv_op = LV_DEC;
        else if (status_i.op != OP_TRANS) cmd_o.ef_op = EF_ZERO;
      end
      S_SCAN: begin
        if (status_i.scan_go) cmd_o.lv_op = LV_INC;
        else cmd_o.ef_op = EF_LV;
      end
      S_BRANCH: begin
        cmd_o.lv_op = status_i.exit_needed ? LV_CUR : LV_EF;
      end
      S_EXIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_EXIT;
          cmd_o.emit_src  = SRC_PATH;
          cmd_o.emit_last = status_i.lv_is_ef && !status_i.enter_follows;
          if (!status_i.lv_is_ef) begin
            cmd_o.lv_op = LV_DEC;
          end else if (status_i.enter_follows) begin
            cmd_o.lv_op = LV_EF;
          end else if (status_i.op == OP_STOP) begin
            cmd_o.stop_machine = 1'b1;
          end else begin
            // target was an active ancestor
            cmd_o.run_target = 1'b1;
          end
        end
      end
      S_ENTER: begin
        if (status_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_kind  = KIND_ENTER;
          cmd_o.emit_src   = SRC_CHAIN;
          cmd_o.emit_last  = status_i.lv_is_tl;
          cmd_o.path_write = 1'b1;
          if (status_i.lv_is_tl) cmd_o.run_target = 1'b1;
          else cmd_o.lv_op = LV_INC;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/hfsm_dp.sv @@
// ----------------------------------------------------------------------------
// hfsm_dp
// Datapath: state table memory, defined flags, active path, target chain,
// level counters and the output register.
// ----------------------------------------------------------------------------
module hfsm_dp #(
  parameter int NUM_STATES = hfsm_pkg::NUM_STATES_DEF,
  parameter int MAX_DEPTH  = hfsm_pkg::MAX_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hfsm_pkg::OP_W-1:0]   opcode_i,
  input  logic [hfsm_pkg::ID_W-1:0]   state_id_i,
  input  logic [hfsm_pkg::ID_W-1:0]   parent_id_i,
  input  hfsm_pkg::cmd_t              cmd_i,
  output hfsm_pkg::status_t           status_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [hfsm_pkg::KIND_W-1:0] event_kind_o,
  output logic [hfsm_pkg::ID_W-1:0]   event_state_o,
  output logic                        is_active_o,
  output logic [hfsm_pkg::ERR_W-1:0]  error_o,
  output logic                        last_o
);
  import hfsm_pkg::*;

  localparam int IW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int LW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = $clog2(MAX_DEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0] parent;
    logic [LW-1:0]   level;
  } entry_t;

  entry_t          node_mem [NUM_STATES];
  entry_t          rd_q;
  logic [NUM_STATES-1:0] defined_q;
  logic [ID_W-1:0] path_q  [MAX_DEPTH];
  logic [ID_W-1:0] chain_q [MAX_DEPTH];

  logic [OP_W-1:0] op_q;
  logic [ID_W-1:0] sid_q, pid_q, x_q;
  logic [LW-1:0]   tl_q, cur_q;
  logic            running_q;
  logic [CW-1:0]   lv_q, ef_q;

  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [ID_W-1:0]   ev_state_q;
  logic              act_q;
  logic [ERR_W-1:0]  err_q;
  logic              last_q;

  logic [IW-1:0]   sid_idx, pid_idx, acc_idx, x_idx;
  logic [LW-1:0]   lv_idx, path_idx, m_lvl;
  logic [ID_W-1:0] path_rd, chain_rd, src_state;
  logic [CW-1:0]   tl_ext, cur_ext, new_level;
  logic            sid_in_range, pid_in_range, sid_known, pid_known;
  logic            query_act, out_free;
  err_e            def_err;
  entry_t          wr_entry;

  assign sid_idx  = IW'(sid_q);
  assign pid_idx  = IW'(pid_q);
  assign x_idx    = IW'(x_q);
  assign acc_idx  = (opcode_i == OP_DEFINE) ? IW'(parent_id_i) : IW'(state_id_i);
  assign lv_idx   = lv_q[LW-1:0];
  assign path_idx = cmd_i.lookup ? rd_q.level : lv_idx;
  assign path_rd  = path_q[path_idx];
  assign chain_rd = chain_q[lv_idx];
  assign tl_ext   = CW'(tl_q);
  assign cur_ext  = CW'(cur_q);
  assign m_lvl    = (cur_q < tl_q) ? cur_q : tl_q;

  assign sid_in_range = (32'(sid_q) < NUM_STATES);
  assign pid_in_range = (32'(pid_q) < NUM_STATES);
  assign sid_known    = sid_in_range && defined_q[sid_idx];
  assign pid_known    = pid_in_range && defined_q[pid_idx];

  // level of a new state; read data holds the parent's entry here
  assign new_level = (sid_q == pid_q) ? '0 : CW'(rd_q.level) + CW'(1);
  assign wr_entry  = '{parent: pid_q, level: new_level[LW-1:0]};

  always_comb begin
    if (!sid_in_range || defined_q[sid_idx] || ((sid_q != pid_q) && !pid_known)) begin
      def_err = ERR_UNKNOWN;
    end else if (new_level >= CW'(MAX_DEPTH)) begin
      def_err = ERR_DEPTH;
    end else begin
      def_err = ERR_OK;
    end
  end

  assign query_act = running_q && (rd_q.level <= cur_q) && (path_rd == sid_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o               = '0;
    status_o.op            = op_q;
    status_o.sid_known     = sid_known;
    status_o.running       = running_q;
    status_o.self_hit      = (cur_q == rd_q.level) && (path_rd == sid_q);
    status_o.def_err       = def_err;
    status_o.scan_go       = (lv_q <= CW'(m_lvl)) && (path_rd == chain_rd);
    status_o.exit_needed   = running_q && (ef_q <= cur_ext);
    status_o.enter_follows = (op_q != OP_STOP) && (ef_q <= tl_ext);
    status_o.lv_zero       = (lv_q == '0);
    status_o.lv_is_ef      = (lv_q == ef_q);
    status_o.lv_is_tl      = (lv_q == tl_ext);
    status_o.out_free      = out_free;
  end

  always_comb begin
    case (cmd_i.emit_src)
      SRC_PATH:  src_state = path_rd;
      SRC_CHAIN: src_state = chain_rd;
      default:   src_state = sid_q;
    endcase
  end

  // state table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.def_write) node_mem[sid_idx] <= wr_entry;
    if (cmd_i.accept) begin
      rd_q <= node_mem[acc_idx];
    end else if (cmd_i.rd_walk) begin
      rd_q <= node_mem[x_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= opcode_i;
      sid_q <= state_id_i;
      pid_q <= parent_id_i;
    end
    if (cmd_i.lookup) tl_q <= rd_q.level;
    if (cmd_i.x_init) begin
      x_q <= sid_q;
    end else if (cmd_i.chain_write) begin
      x_q <= rd_q.parent;
    end
    if (cmd_i.chain_write) chain_q[lv_idx] <= x_q;
    if (cmd_i.path_write) path_q[lv_idx] <= chain_rd;
    case (cmd_i.lv_op)
      LV_INC:  lv_q <= lv_q + CW'(1);
      LV_DEC:  lv_q <= lv_q - CW'(1);
      LV_TL:   lv_q <= CW'(rd_q.level);
      LV_CUR:  lv_q <= cur_ext;
      LV_EF:   lv_q <= ef_q;
      default: ;
    endcase
    case (cmd_i.ef_op)
      EF_ZERO: ef_q <= '0;
      EF_LV:   ef_q <= lv_q;
      default: ;
    endcase
    if (cmd_i.emit) begin
      kind_q     <= cmd_i.emit_kind;
      ev_state_q <= src_state;
      act_q      <= (cmd_i.emit_kind == KIND_QUERY) && (cmd_i.emit_err == ERR_OK) &&
                    query_act;
      err_q      <= cmd_i.emit_err;
      last_q     <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      defined_q   <= '0;
      running_q   <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.def_write) defined_q[sid_idx] <= 1'b1;
      if (cmd_i.stop_machine) begin
        running_q <= 1'b0;
        cur_q     <= '0;
      end else if (cmd_i.run_target) begin
        running_q <= 1'b1;
        cur_q     <= tl_q;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign event_state_o = ev_state_q;
  assign is_active_o   = act_q;
  assign error_o       = err_q;
  assign last_o        = last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result issued while output register occupied");

  a_no_redefine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.def_write |-> !defined_q[sid_idx])
    else $error("state table entry written twice");

  a_stop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(running_q) |-> $past(cmd_i.stop_machine))
    else $error("machine stopped without stop command");

  a_enter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.path_write |-> (lv_q <= tl_ext))
    else $error("active path written beyond target level");

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hierarchical state machine sequencer. A short
// table of directed commands walks the corner cases (unknown ids, redefinition,
// depth overflow, self and ancestor transitions, restart while running,
// reserved opcodes). A longer random phase then builds state trees and drives
// commands with random content, reserved opcodes and unknown ids included. A
// built-in predictor checks every result transaction. Sender bursts, receiver
// stalls and one long receiver hold-off give back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import hfsm_pkg::*;

  localparam int NSTATE      = NUM_STATES_DEF;
  localparam int DEPTH       = MAX_DEPTH_DEF;
  localparam int RAND_CMDS   = 330;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;
  localparam int CYCLE_LIMIT = 400000;

  // opcodes outside the command set, answered with a plain completion and no other effect
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] state;
    logic            active;
    err_e            err;
    logic            last;
  } hsm_event_t;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] sid;
    logic [ID_W-1:0] pid;
    bit              typed;
    kind_e           kind;
    err_e            err;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   opcode;
  logic [ID_W-1:0]   state_id;
  logic [ID_W-1:0]   parent_id;
  logic              out_valid;
  logic              out_stall;
  logic [KIND_W-1:0] event_kind;
  logic [ID_W-1:0]   event_state;
  logic              is_active;
  logic [ERR_W-1:0]  error_code;
  logic              ev_last;

  // predictor copy of the block state
  logic [ID_W-1:0] par_tab  [NSTATE];
  logic [2:0]      lvl_tab  [NSTATE];
  bit              def_tab  [NSTATE];
  logic [ID_W-1:0] act_path [DEPTH];
  logic [ID_W-1:0] chain_buf[DEPTH];
  int              cur_lvl;
  bit              run_flag;
  int              num_defined;
  int              deepest;

  hsm_event_t expected_events[$];
  hsm_event_t exp_ev;
  dir_row_t   dir_rows[$];

  int fail_cnt;
  int cycle_cnt;
  int burst_left;
  int cmd_cnt;
  int n_exit, n_enter, n_query, n_done;
  bit hold_req;
  bit holding;

  hierarchical_fsm_transition_sequencer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .state_id_i    (state_id),
    .parent_id_i   (parent_id),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .event_kind_o  (event_kind),
    .event_state_o (event_state),
    .is_active_o   (is_active),
    .error_o       (error_code),
    .last_o        (ev_last)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_events.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  task automatic push_event(kind_e k, logic [ID_W-1:0] s, logic a, err_e e);
    hsm_event_t ev;
    ev.kind   = k;
    ev.state  = s;
    ev.active = a;
    ev.err    = e;
    ev.last   = 1'b0;
    expected_events = {expected_events, ev};
  endtask

  task automatic exit_path();
    for (int lv = cur_lvl; lv >= 0; lv--) push_event(KIND_EXIT, act_path[lv], 1'b0, ERR_OK);
    run_flag = 1'b0;
    cur_lvl  = 0;
  endtask

  // ancestors of a state and the state itself, root first, into chain_buf
  task automatic build_chain(logic [ID_W-1:0] tgt, int lvl);
    logic [ID_W-1:0] x;
    x = tgt;
    for (int lv = lvl; lv >= 0; lv--) begin
      chain_buf[lv] = x;
      x = par_tab[x];
    end
  endtask

  task automatic predict_events(logic [OP_W-1:0] op, logic [ID_W-1:0] sid,
                                logic [ID_W-1:0] pid);
    int         tl;
    int         cl;
    int         m;
    int         k;
    int         n0;
    hsm_event_t ev;
    n0 = expected_events.size();
    case (op)
      OP_DEFINE: begin
        if (def_tab[sid] || (sid != pid && !def_tab[pid])) begin
          push_event(KIND_DONE, sid, 1'b0, ERR_UNKNOWN);
        end else begin
          tl = (sid == pid) ? 0 : int'(lvl_tab[pid]) + 1;
          if (tl >= DEPTH) begin
            push_event(KIND_DONE, sid, 1'b0, ERR_DEPTH);
          end else begin
            par_tab[sid] = pid;
            lvl_tab[sid] = tl[2:0];
            def_tab[sid] = 1'b1;
            num_defined++;
            push_event(KIND_DONE, sid, 1'b0, ERR_OK);
          end
        end
      end
      OP_START: begin
        if (!def_tab[sid]) begin
          push_event(KIND_DONE, sid, 1'b0, ERR_UNKNOWN);
        end else begin
          tl = int'(lvl_tab[sid]);
          if (run_flag) exit_path();
          build_chain(sid, tl);
          for (int lv = 0; lv <= tl; lv++) begin
            act_path[lv] = chain_buf[lv];
            push_event(KIND_ENTER, chain_buf[lv], 1'b0, ERR_OK);
          end
          cur_lvl  = tl;
          run_flag = 1'b1;
        end
      end
      OP_TRANS: begin
        if (!run_flag) begin
          push_event(KIND_DONE, sid, 1'b0, ERR_OK);
        end else if (!def_tab[sid]) begin
          push_event(KIND_DONE, sid, 1'b0, ERR_UNKNOWN);
        end else begin
          tl = int'(lvl_tab[sid]);
          cl = cur_lvl;
          if (cl == tl && act_path[cl] == sid) begin
            push_event(KIND_EXIT, sid, 1'b0, ERR_OK);
            push_event(KIND_ENTER, sid, 1'b0, ERR_OK);
          end else begin
            m = (cl < tl) ? cl : tl;
            k = -1;
            build_chain(sid, tl);
            // deepest level shared by the active path and the target's chain
            for (int lv = 0; lv <= m; lv++) begin
              if (act_path[lv] != chain_buf[lv]) break;
              k = lv;
            end
            for (int lv = cl; lv > k; lv--) push_event(KIND_EXIT, act_path[lv], 1'b0, ERR_OK);
            for (int lv = k + 1; lv <= tl; lv++) begin
              act_path[lv] = chain_buf[lv];
              push_event(KIND_ENTER, chain_buf[lv], 1'b0, ERR_OK);
            end
            cur_lvl = tl;
            if (expected_events.size() == n0) push_event(KIND_DONE, sid, 1'b0, ERR_OK);
          end
        end
      end
      OP_STOP: begin
        if (run_flag) exit_path();
        else          push_event(KIND_DONE, sid, 1'b0, ERR_OK);
      end
      OP_QUERY: begin
        if (!def_tab[sid]) begin
          push_event(KIND_QUERY, sid, 1'b0, ERR_UNKNOWN);
        end else begin
          tl = int'(lvl_tab[sid]);
          push_event(KIND_QUERY, sid, run_flag && tl <= cur_lvl && act_path[tl] == sid,
                     ERR_OK);
        end
      end
      default: push_event(KIND_DONE, sid, 1'b0, ERR_OK);
    endcase
    if (cur_lvl > deepest && run_flag) deepest = cur_lvl;
    ev = expected_events.pop_back();
    ev.last = 1'b1;
    expected_events = {expected_events, ev};
  endtask

  // ------------------------------------------------------------------ sender
  task automatic send_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] sid,
                          logic [ID_W-1:0] pid);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) < 3 || holding) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid  <= 1'b1;
    opcode    <= op;
    state_id  <= sid;
    parent_id <= pid;
    do @(posedge clk_i); while (in_stall);
    cmd_cnt++;
  endtask

  task automatic add_row(logic [OP_W-1:0] op, logic [ID_W-1:0] sid,
                         logic [ID_W-1:0] pid, bit typed, kind_e k, err_e e);
    dir_row_t row;
    row.op    = op;
    row.sid   = sid;
    row.pid   = pid;
    row.typed = typed;
    row.kind  = k;
    row.err   = e;
    dir_rows = {dir_rows, row};
  endtask

  // a defined state where one is found quickly, else any id
  function automatic logic [ID_W-1:0] pick_state();
    logic [ID_W-1:0] id;
    for (int i = 0; i < 6; i++) begin
      id = ID_W'($urandom_range(0, NSTATE - 1));
      if (def_tab[id]) return id;
    end
    return id;
  endfunction

  // deepest of a few picks, so that trees grow towards the depth limit
  function automatic logic [ID_W-1:0] pick_deep();
    logic [ID_W-1:0] best;
    logic [ID_W-1:0] cand;
    best = pick_state();
    for (int i = 0; i < 2; i++) begin
      cand = pick_state();
      if (def_tab[cand] && (!def_tab[best] || lvl_tab[cand] > lvl_tab[best])) best = cand;
    end
    return best;
  endfunction

  // ---------------------------------------------------------------- receiver
  initial begin
    int seg;
    int pct;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i) out_stall <= 1'b1;
        holding  = 1'b0;
      end else begin
        seg = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       pct = 0;
          1:       pct = 30;
          default: pct = 75;
        endcase
        repeat (seg) @(negedge clk_i) out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  task automatic check_field(string name, logic [ID_W-1:0] exp_val,
                             logic [ID_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result transaction: kind %0d state %0d", event_kind, event_state);
        fail_cnt++;
      end else begin
        exp_ev = expected_events.pop_front();
        check_field("event_kind", ID_W'(exp_ev.kind), ID_W'(event_kind));
        check_field("event_state", exp_ev.state, event_state);
        check_field("is_active", ID_W'(exp_ev.active), ID_W'(is_active));
        check_field("error", ID_W'(exp_ev.err), ID_W'(error_code));
        check_field("last", ID_W'(exp_ev.last), ID_W'(ev_last));
        case (exp_ev.kind)
          KIND_EXIT:  n_exit++;
          KIND_ENTER: n_enter++;
          KIND_QUERY: n_query++;
          default:    n_done++;
        endcase
      end
    end
  end

  // -------------------------------------------------------------------- main
  initial begin
    int               n0;
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  sid;
    logic [ID_W-1:0]  pid;
    int               r;
    hsm_event_t       ev;

    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    opcode    = '0;
    state_id  = '0;
    parent_id = '0;
    for (int i = 0; i < NSTATE; i++) begin
      def_tab[i] = 1'b0;
      par_tab[i] = '0;
      lvl_tab[i] = '0;
    end
    for (int i = 0; i < DEPTH; i++) act_path[i] = '0;
    cur_lvl = 0;
    run_flag = 1'b0;

    // before anything is defined
    add_row(OP_QUERY, 5, 0, 1, KIND_QUERY, ERR_UNKNOWN);
    add_row(OP_TRANS, 5, 0, 1, KIND_DONE, ERR_OK);
    add_row(OP_STOP, 0, 0, 1, KIND_DONE, ERR_OK);
    add_row(OP_START, 5, 0, 1, KIND_DONE, ERR_UNKNOWN);
    // redefinition, unknown parent, a chain down to the deepest level, then one too deep
    add_row(OP_DEFINE, 0, 0, 1, KIND_DONE, ERR_OK);
    add_row(OP_DEFINE, 0, 0, 1, KIND_DONE, ERR_UNKNOWN);
    add_row(OP_DEFINE, 1, 63, 1, KIND_DONE, ERR_UNKNOWN);
    for (int i = 1; i < DEPTH; i++) begin
      add_row(OP_DEFINE, ID_W'(i), ID_W'(i - 1), 1, KIND_DONE, ERR_OK);
    end
    add_row(OP_DEFINE, ID_W'(DEPTH), ID_W'(DEPTH - 1), 1, KIND_DONE, ERR_DEPTH);
    add_row(OP_DEFINE, 63, 63, 1, KIND_DONE, ERR_OK);
    add_row(OP_DEFINE, 62, 63, 1, KIND_DONE, ERR_OK);
    // walk the machine
    add_row(OP_QUERY, 62, 0, 0, KIND_DONE, ERR_OK);
    add_row(OP_START, ID_W'(DEPTH - 1), 0, 0, KIND_DONE, ERR_OK);
    add_row(OP_QUERY, 3, 0, 0, KIND_DONE, ERR_OK);
    add_row(OP_TRANS, 62, 0, 0, KIND_DONE, ERR_OK);
    add_row(OP_TRANS, 62, 0, 0, KIND_DONE, ERR_OK);
    add_row(OP_TRANS, 63, 0, 0, KIND_DONE, ERR_OK);
    add_row(OP_START, ID_W'(DEPTH - 1), 0, 0, KIND_DONE, ERR_OK);
    add_row(OP_TRANS, 2, 0, 0, KIND_DONE, ERR_OK);
    add_row(OP_TRANS, ID_W'(DEPTH), 0, 1, KIND_DONE, ERR_UNKNOWN);
    add_row(OP_RSVD_HI, 42, 21, 1, KIND_DONE, ERR_OK);
    add_row(OP_RSVD_LO, 21, 42, 1, KIND_DONE, ERR_OK);
    add_row(OP_STOP, 0, 0, 0, KIND_DONE, ERR_OK);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].op, dir_rows[i].sid, dir_rows[i].pid);
      n0 = expected_events.size();
      predict_events(dir_rows[i].op, dir_rows[i].sid, dir_rows[i].pid);
      if (dir_rows[i].typed) begin
        while (expected_events.size() > n0) ev = expected_events.pop_back();
        push_event(dir_rows[i].kind, dir_rows[i].sid, 1'b0, dir_rows[i].err);
        ev = expected_events.pop_back();
        ev.last = 1'b1;
        expected_events = {expected_events, ev};
      end
    end

    for (int i = 0; i < RAND_CMDS; i++) begin
      if (i == 120) hold_req = 1'b1;
      pid = ID_W'($urandom_range(0, NSTATE - 1));
      if ($urandom_range(0, 99) < ((num_defined < 48) ? 40 : 8)) begin
        op  = OP_DEFINE;
        sid = ID_W'($urandom_range(0, NSTATE - 1));
        r   = $urandom_range(0, 99);
        if (r < 15)      pid = sid;
        else if (r < 90) pid = pick_deep();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 16)      op = OP_START;
        else if (r < 62) op = OP_TRANS;
        else if (r < 72) op = OP_STOP;
        else if (r < 94) op = OP_QUERY;
        else             op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        sid = ($urandom_range(0, 99) < 85) ? pick_state() :
                                             ID_W'($urandom_range(0, NSTATE - 1));
      end
      send_cmd(op, sid, pid);
      predict_events(op, sid, pid);
    end
    @(negedge clk_i) in_valid <= 1'b0;

    for (int w = 0; w < DRAIN_LIMIT && expected_events.size() != 0; w++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (expected_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      fail_cnt++;
    end

    $display("Ran %0d commands over %0d defined states, active path down to level %0d.",
             cmd_cnt, num_defined, deepest);
    $display("Checked %0d exits, %0d entries, %0d query answers, %0d plain completions.",
             n_exit, n_enter, n_query, n_done);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/hfsm_pkg.sv
rtl/hfsm_ctrl.sv
rtl/hfsm_dp.sv
rtl/hierarchical_fsm_transition_sequencer_unit.sv
dv/tb.sv
